// File: hw/rtl/plane_wave_pulse_field_assert.svh
// assertion macros shared by the field generator modules
`ifndef PLANE_WAVE_PULSE_FIELD_ASSERT_SVH
`define PLANE_WAVE_PULSE_FIELD_ASSERT_SVH

// same-cycle implication
`define PWPF_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("pwpf assertion failed");

// next-cycle implication
`define PWPF_ASSERT_NXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("pwpf assertion failed");

`endif

// File: hw/rtl/pwpf_pkg.sv
// types and constants of the plane-wave pulse field generator
package pwpf_pkg;

	localparam int ATAN_N = 30;
	localparam logic [31:0] ATAN_TURNS [ATAN_N] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};

	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic [29:0] INV_2PI = 30'd683565276;
	localparam logic [30:0] ONE_Q30 = 31'h40000000;

	localparam int KT_W = 53;
	localparam int TH_W = 36;

	typedef enum logic [2:0] {
		SEG_ZERO = 3'b001,
		SEG_ONE  = 3'b010,
		SEG_RAMP = 3'b100
	} seg_t;

	typedef enum logic [2:0] {
		REG_PULSE_START = 3'd0,
		REG_RISE_LENGTH = 3'd1,
		REG_FLAT_LENGTH = 3'd2,
		REG_FALL_LENGTH = 3'd3,
		REG_WAVE_NUMBER = 3'd4,
		REG_AMP_COS     = 3'd5,
		REG_AMP_SIN     = 3'd6,
		REG_CELL_SIZE   = 3'd7
	} reg_idx_t;

	// envelope thresholds in half units and the carrier factor
	typedef struct packed {
		logic signed [TH_W-1:0] st;
		logic signed [TH_W-1:0] rise_lo;
		logic signed [TH_W-1:0] flat_lo;
		logic signed [TH_W-1:0] tail;
		logic [31:0]            ri;
		logic [31:0]            fa;
		logic [KT_W-1:0]        kt;
	} env_cfg_t;

endpackage

// File: hw/rtl/pwpf_cordic.sv
// pipelined rotation cordic giving cos and sin of a phase in turns
module pwpf_cordic import pwpf_pkg::*; #(
	parameter int STAGES = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  logic [31:0]        phase,
	output logic               out_v,
	output logic signed [32:0] cos_o,
	output logic signed [32:0] sin_o
);

	localparam int XW = 33;
	localparam int AW = 34;

	logic signed [XW-1:0] x_s [STAGES+1];
	logic signed [XW-1:0] y_s [STAGES+1];
	logic signed [AW-1:0] a_s [STAGES+1];
	logic                 flip_s [STAGES+1];
	logic                 v_s [STAGES+1];

	logic        flip;
	logic [31:0] folded;

	// fold into the half turn around zero
	assign flip   = phase[31] ^ phase[30];
	assign folded = {phase[31] ^ flip, phase[30:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= CORDIC_GAIN;
			y_s[0]    <= '0;
			a_s[0]    <= AW'($signed(folded));
			flip_s[0] <= flip;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic signed [XW-1:0] dx;
		logic signed [XW-1:0] dy;
		logic signed [AW-1:0] da;

		assign dx = x_s[i] >>> i;
		assign dy = y_s[i] >>> i;
		assign da = $signed(AW'(ATAN_TURNS[i]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (a_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - dy;
					y_s[i+1] <= y_s[i] + dx;
					a_s[i+1] <= a_s[i] - da;
				end else begin
					x_s[i+1] <= x_s[i] + dy;
					y_s[i+1] <= y_s[i] - dx;
					a_s[i+1] <= a_s[i] + da;
				end
				flip_s[i+1] <= flip_s[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= v_s[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_o <= flip_s[STAGES] ? -x_s[STAGES] : x_s[STAGES];
			sin_o <= flip_s[STAGES] ? -y_s[STAGES] : y_s[STAGES];
		end
	end

endmodule

// File: hw/rtl/pwpf_lane.sv
// one position: envelope segment, ramp divider, two cordics and the weight product
`include "plane_wave_pulse_field_assert.svh"
module pwpf_lane import pwpf_pkg::*; #(
	parameter int ZD_W        = 49,
	parameter int TRIG_STAGES = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  env_cfg_t           cfg,
	input  logic               in_v,
	input  logic [ZD_W-1:0]    zd,
	output logic               out_v,
	output logic signed [33:0] w
);

	localparam int CMP_W = ZD_W + 1;
	localparam int PW    = 57;
	localparam int DIV_N = 31;
	localparam int CD_N  = TRIG_STAGES + 2;

	// segment select and carrier partial products
	logic signed [CMP_W-1:0] zs;
	logic signed [CMP_W-1:0] st_x, tail_x;
	logic [PW-1:0]           zx;
	logic [26:0]             kl;
	logic [25:0]             kh;
	seg_t                    seg_c;
	logic [31:0]             num_c, den_c;

	assign zs     = $signed({1'b0, zd});
	assign st_x   = CMP_W'(cfg.st);
	assign tail_x = CMP_W'(cfg.tail);
	assign zx     = PW'(zd);
	assign kl     = cfg.kt[26:0];
	assign kh     = cfg.kt[52:27];

	always_comb begin
		seg_c = SEG_ZERO;
		num_c = '0;
		den_c = 32'd1;
		priority if (zs > st_x) begin
			seg_c = SEG_ZERO;
		end else if (zs > CMP_W'(cfg.rise_lo)) begin
			seg_c = SEG_RAMP;
			num_c = 32'(st_x - zs);
			den_c = cfg.ri;
		end else if (zs > CMP_W'(cfg.flat_lo)) begin
			seg_c = SEG_ONE;
		end else if (zs > tail_x) begin
			seg_c = SEG_RAMP;
			num_c = 32'(zs - tail_x);
			den_c = cfg.fa;
		end else begin
			seg_c = SEG_ZERO;
		end
	end

	logic        v_s1;
	seg_t        seg_s1;
	logic [31:0] num_s1, den_s1;
	logic [54:0] p0_s1;
	logic [55:0] p1_s1;
	logic [53:0] p2_s1;
	logic [1:0]  p3_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1 <= seg_c;
			num_s1 <= num_c;
			den_s1 <= den_c;
			p0_s1  <= kl * zx[27:0];
			p1_s1  <= kl * zx[56:28];
			p2_s1  <= kh * zx[27:0];
			p3_s1  <= kh[1:0] * zx[29:28];
		end
	end

	// carrier phase sum, then restoring divider carrying the phase along
	logic [PW-1:0] psum;
	assign psum = PW'(p0_s1) + (PW'(p1_s1) << 28) + (PW'(p2_s1) << 27) + {p3_s1, 55'd0};

	logic [31:0] div_rem_s [DIV_N+1];
	logic [30:0] div_quo_s [DIV_N+1];
	logic [31:0] div_den_s [DIV_N+1];
	logic [31:0] div_ph_s  [DIV_N+1];
	seg_t        div_seg_s [DIV_N+1];
	logic        div_v_s   [DIV_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s[0] <= 1'b0;
		end else if (en) begin
			div_v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_rem_s[0] <= num_s1;
			div_quo_s[0] <= '0;
			div_den_s[0] <= den_s1;
			div_ph_s[0]  <= psum[56:25];
			div_seg_s[0] <= seg_s1;
		end
	end

	for (genvar j = 0; j < DIV_N; j++) begin : g_div
		logic [32:0] t;
		logic        ge;

		// first step takes the remainder as it is, later ones double it
		assign t  = (j == 0) ? {1'b0, div_rem_s[j]} : {div_rem_s[j], 1'b0};
		assign ge = t >= {1'b0, div_den_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[j+1] <= 1'b0;
			end else if (en) begin
				div_v_s[j+1] <= div_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_s[j+1] <= ge ? 32'(t - {1'b0, div_den_s[j]}) : t[31:0];
				div_quo_s[j+1] <= {div_quo_s[j][29:0], ge};
				div_den_s[j+1] <= div_den_s[j];
				div_ph_s[j+1]  <= div_ph_s[j];
				div_seg_s[j+1] <= div_seg_s[j];
			end
		end
	end

	// ramp sine and carrier cosine side by side
	logic               rv, cv;
	logic signed [32:0] ramp_sin, car_cos;

	pwpf_cordic #(.STAGES(TRIG_STAGES)) u_cordic_ramp (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (div_v_s[DIV_N]),
		.phase  ({1'b0, div_quo_s[DIV_N]}),
		.out_v  (rv),
		.cos_o  (),
		.sin_o  (ramp_sin)
	);

	pwpf_cordic #(.STAGES(TRIG_STAGES)) u_cordic_car (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (div_v_s[DIV_N]),
		.phase  (div_ph_s[DIV_N]),
		.out_v  (cv),
		.cos_o  (car_cos),
		.sin_o  ()
	);

	seg_t seg_d [CD_N];

	always_ff @(posedge clk) begin
		if (en) begin
			seg_d[0] <= div_seg_s[DIV_N];
			for (int k = 1; k < CD_N; k++) begin
				seg_d[k] <= seg_d[k-1];
			end
		end
	end

	// sin squared, envelope select, weight product and rounding
	logic               v_s3, v_s4, v_s5, v_s6;
	logic signed [65:0] sq_s3;
	logic signed [32:0] c_s3, c_s4;
	seg_t               seg_s3;
	logic [30:0]        env_s4;
	logic signed [64:0] pw_s5;
	logic signed [33:0] w_s6;
	logic signed [65:0] e_rnd;
	logic [30:0]        env_c;

	assign e_rnd = (sq_s3 + 66'sd536870912) >>> 30;

	always_comb begin
		unique case (seg_s3)
			SEG_ONE:  env_c = ONE_Q30;
			SEG_RAMP: env_c = (e_rnd > 66'sd1073741824) ? ONE_Q30 : e_rnd[30:0];
			default:  env_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s3 <= rv & cv;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3  <= ramp_sin * ramp_sin;
			c_s3   <= car_cos;
			seg_s3 <= seg_d[CD_N-1];
			env_s4 <= env_c;
			c_s4   <= c_s3;
			pw_s5  <= $signed({2'b0, env_s4}) * c_s4;
			w_s6   <= 34'((pw_s5 + 65'sd536870912) >>> 30);
		end
	end

	assign out_v = v_s6;
	assign w     = w_s6;

	`PWPF_ASSERT_IMP(a_cordic_sync, 1'b1, rv == cv)
	`PWPF_ASSERT_IMP(a_quot_range, div_v_s[DIV_N] && div_seg_s[DIV_N] == SEG_RAMP, div_quo_s[DIV_N] <= ONE_Q30)
	`PWPF_ASSERT_IMP(a_env_range, v_s4, env_s4 <= ONE_Q30)

endmodule

// File: hw/rtl/plane_wave_pulse_field.sv
// top level of the plane-wave pulse field generator
//
// channel | handshake             | payload
// in      | in_valid / in_stall   | cell_column
// out     | out_valid / out_stall | e_y, e_z, b_y, b_z
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per cycle while no valid output item is stalled
// the 31-step ramp divider and the two cordic chains set the depth
// reset clears all valid bits and loads the register defaults
// a stall on a valid output item freezes the whole pipeline and stalls the input
`include "plane_wave_pulse_field_assert.svh"
module plane_wave_pulse_field import pwpf_pkg::*; #(
	parameter int INDEX_BITS  = 16,
	parameter int TRIG_STAGES = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [INDEX_BITS-1:0] cell_column,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [31:0]    e_y,
	output logic signed [31:0]    e_z,
	output logic signed [31:0]    b_y,
	output logic signed [31:0]    b_z,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data
);

	localparam int ZD_W = INDEX_BITS + 33;
	localparam int PR_W = INDEX_BITS + 31;

	// register file
	logic [31:0] pulse_start_q, amp_cos_q, amp_sin_q;
	logic [30:0] rise_length_q, flat_length_q, fall_length_q, wave_number_q, cell_size_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_start_q <= '0;
			rise_length_q <= 31'd65536;
			flat_length_q <= '0;
			fall_length_q <= 31'd65536;
			wave_number_q <= '0;
			amp_cos_q     <= '0;
			amp_sin_q     <= '0;
			cell_size_q   <= 31'd65536;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PULSE_START: pulse_start_q <= cfg_data;
				REG_RISE_LENGTH: rise_length_q <= cfg_data[30:0];
				REG_FLAT_LENGTH: flat_length_q <= cfg_data[30:0];
				REG_FALL_LENGTH: fall_length_q <= cfg_data[30:0];
				REG_WAVE_NUMBER: wave_number_q <= cfg_data[30:0];
				REG_AMP_COS:     amp_cos_q     <= cfg_data;
				REG_AMP_SIN:     amp_sin_q     <= cfg_data;
				REG_CELL_SIZE:   cell_size_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// thresholds in half units and k/(2 pi), refreshed every cycle
	env_cfg_t               env_cfg_q;
	logic signed [TH_W-1:0] st_c, rise_lo_c, flat_lo_c, tail_c;
	logic [60:0]            kt_prod;

	assign st_c      = TH_W'($signed({pulse_start_q, 1'b0}));
	assign rise_lo_c = st_c - $signed(TH_W'({rise_length_q, 1'b0}));
	assign flat_lo_c = rise_lo_c - $signed(TH_W'({flat_length_q, 1'b0}));
	assign tail_c    = flat_lo_c - $signed(TH_W'({fall_length_q, 1'b0}));
	assign kt_prod   = 61'(wave_number_q) * 61'(INV_2PI);

	always_ff @(posedge clk) begin
		env_cfg_q.st      <= st_c;
		env_cfg_q.rise_lo <= rise_lo_c;
		env_cfg_q.flat_lo <= flat_lo_c;
		env_cfg_q.tail    <= tail_c;
		env_cfg_q.ri      <= {rise_length_q, 1'b0};
		env_cfg_q.fa      <= {fall_length_q, 1'b0};
		env_cfg_q.kt      <= kt_prod[60:8];
	end

	// global advance: everything moves unless the output item is held
	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	assign en       = !(v_s4 && out_stall);
	assign in_stall = !en;

	logic [PR_W-1:0] prod_s1;
	logic [ZD_W-1:0] ze_s2, zb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PR_W'(cell_column) * PR_W'(cell_size_q);
			ze_s2   <= ZD_W'({prod_s1, 1'b0});
			zb_s2   <= ZD_W'({prod_s1, 1'b0}) + ZD_W'(cell_size_q);
		end
	end

	logic               ve, vb;
	logic signed [33:0] we, wb;

	pwpf_lane #(.ZD_W(ZD_W), .TRIG_STAGES(TRIG_STAGES)) u_lane_e (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cfg    (env_cfg_q),
		.in_v   (v_s2),
		.zd     (ze_s2),
		.out_v  (ve),
		.w      (we)
	);

	pwpf_lane #(.ZD_W(ZD_W), .TRIG_STAGES(TRIG_STAGES)) u_lane_b (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cfg    (env_cfg_q),
		.in_v   (v_s2),
		.zd     (zb_s2),
		.out_v  (vb),
		.w      (wb)
	);

	function automatic logic [31:0] rnd_sat(input logic signed [65:0] p, input logic neg);
		logic signed [36:0] r;
		r = 37'((p + 66'sd536870912) >>> 30);
		if (neg) begin
			r = -r;
		end
		if (r > 37'sd2147483647) begin
			return 32'h7fffffff;
		end else if (r < -37'sd2147483648) begin
			return 32'h80000000;
		end
		return r[31:0];
	endfunction

	logic signed [65:0] ey_s3, ez_s3, by_s3, bz_s3;
	logic [31:0]        ey_s4, ez_s4, by_s4, bz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= ve & vb;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ey_s3 <= $signed(amp_cos_q) * we;
			ez_s3 <= $signed(amp_sin_q) * we;
			by_s3 <= $signed(amp_sin_q) * wb;
			bz_s3 <= $signed(amp_cos_q) * wb;
			ey_s4 <= rnd_sat(ey_s3, 1'b0);
			ez_s4 <= rnd_sat(ez_s3, 1'b0);
			by_s4 <= rnd_sat(by_s3, 1'b1);
			bz_s4 <= rnd_sat(bz_s3, 1'b0);
		end
	end

	assign out_valid = v_s4;
	assign e_y       = ey_s4;
	assign e_z       = ez_s4;
	assign b_y       = by_s4;
	assign b_z       = bz_s4;

	`PWPF_ASSERT_IMP(a_lanes_agree, 1'b1, ve == vb)
	`PWPF_ASSERT_NXT(a_item_enters, in_valid && !in_stall, v_s1)
	`PWPF_ASSERT_NXT(a_item_leaves, v_s3 && en, out_valid)

endmodule

// File: sim/tb_plane_wave_pulse_field.sv
// testbench of the plane-wave pulse field generator, self-checking against its own field predictor
`timescale 1ns / 1ps
module tb_plane_wave_pulse_field import pwpf_pkg::*;;

	localparam int N_STAGES = 20;
	localparam int LATENCY  = N_STAGES + 43;
	localparam longint HALF_Q30 = 64'sd536870912;
	localparam longint ONE_Q30L = 64'sd1073741824;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic signed [31:0] e_y;
		logic signed [31:0] e_z;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
	} field_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] cell_column = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] e_y, e_z, b_y, b_z;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	reg_idx_t cfg_index = REG_PULSE_START;
	logic [31:0] cfg_data = '0;

	// shadow copy of the register file
	logic [31:0] pulse_start_q;
	logic [30:0] rise_q, flat_q, fall_q, wave_q, cell_q;
	logic [31:0] amp_cos_q, amp_sin_q;

	field_t pending_fields[$];
	int n_sent, n_checked, n_errors, n_cfg;
	int cycles;
	bit no_gaps;

	plane_wave_pulse_field u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .cell_column(cell_column),
		.out_valid(out_valid), .out_stall(out_stall),
		.e_y(e_y), .e_z(e_z), .b_y(b_y), .b_z(b_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("tb_plane_wave_pulse_field NOT OK");
			$finish;
		end
	end

	function automatic longint round30(input longint v);
		return (v + HALF_Q30) >>> 30;
	endfunction

	function automatic logic [31:0] clip32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	// rotation in 32-bit turns, folded into the right half plane
	task automatic rotate(input logic [31:0] ph, output longint c, output longint s);
		logic [31:0] tmp;
		logic flip;
		longint x, y, a, dx, dy;
		tmp = ph + 32'h40000000;
		flip = tmp[31];
		if (flip)
			ph = ph + 32'h80000000;
		a = longint'($signed(ph));
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < N_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (a >= 0) begin
				x = x - dx; y = y + dy; a = a - longint'({32'd0, ATAN_TURNS[i]});
			end else begin
				x = x + dx; y = y - dy; a = a + longint'({32'd0, ATAN_TURNS[i]});
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic ramp_sin2(input longint unsigned num, input longint unsigned den,
			output longint e);
		longint unsigned ph;
		longint c, s;
		if (den == 0) begin
			e = 0;
			return;
		end
		if (num > den)
			num = den;
		ph = (num << 30) / den;
		rotate(ph[31:0], c, s);
		e = round30(s * s);
		if (e < 0) e = 0;
		if (e > ONE_Q30L) e = ONE_Q30L;
	endtask

	// envelope at a doubled position, Q1.30
	task automatic envelope_at(input longint zd, output longint e);
		longint st, ri, fl, fa, tail;
		st = 2 * longint'($signed(pulse_start_q));
		ri = 2 * longint'({33'd0, rise_q});
		fl = 2 * longint'({33'd0, flat_q});
		fa = 2 * longint'({33'd0, fall_q});
		tail = st - ri - fl - fa;
		if (zd > st)
			e = 0;
		else if (zd > st - ri)
			ramp_sin2(st - zd, ri, e);
		else if (zd > st - ri - fl)
			e = ONE_Q30L;
		else if (zd > tail)
			ramp_sin2(zd - tail, fa, e);
		else
			e = 0;
	endtask

	task automatic carrier_weight(input longint unsigned zd, output longint w);
		longint unsigned kt, p;
		longint c, s, env;
		kt = ({33'd0, wave_q} * 64'd683565276) >> 8;
		p = kt * zd;
		rotate(p[56:25], c, s);
		envelope_at(longint'(zd), env);
		w = round30(env * c);
	endtask

	task automatic predict_fields(input logic [15:0] col, output field_t f);
		longint unsigned ze, zb;
		longint ac, as_, we, wb;
		ze = 64'(col) * 64'(cell_q) * 2;
		zb = ze + 64'(cell_q);
		ac = longint'($signed(amp_cos_q));
		as_ = longint'($signed(amp_sin_q));
		carrier_weight(ze, we);
		carrier_weight(zb, wb);
		f.e_y = clip32(round30(ac * we));
		f.e_z = clip32(round30(as_ * we));
		f.b_y = clip32(-round30(as_ * wb));
		f.b_z = clip32(round30(ac * wb));
	endtask

	// result checker: values are stable at the falling edge before the accepting edge
	always @(negedge clk) begin
		field_t exp_f;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_fields.size() == 0) begin
				$display("%0t: unexpected result e_y=%h e_z=%h b_y=%h b_z=%h",
					$time, e_y, e_z, b_y, b_z);
				n_errors++;
			end else begin
				exp_f = pending_fields.pop_front();
				n_checked++;
				if (e_y !== exp_f.e_y) begin
					$display("%0t: e_y expected %h got %h", $time, exp_f.e_y, e_y);
					n_errors++;
				end
				if (e_z !== exp_f.e_z) begin
					$display("%0t: e_z expected %h got %h", $time, exp_f.e_z, e_z);
					n_errors++;
				end
				if (b_y !== exp_f.b_y) begin
					$display("%0t: b_y expected %h got %h", $time, exp_f.b_y, b_y);
					n_errors++;
				end
				if (b_z !== exp_f.b_z) begin
					$display("%0t: b_z expected %h got %h", $time, exp_f.b_z, b_z);
					n_errors++;
				end
			end
		end
	end

	// receiver back-pressure, a fresh hold-off for every item
	initial begin
		bit taken;
		@(posedge arst_n);
		forever begin
			int n;
			n = no_gaps ? 0 : $urandom_range(0, 11);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do begin
				@(negedge clk);
				taken = out_valid;
				@(posedge clk);
			end while (!taken);
		end
	end

	task automatic send_column(input logic [15:0] col);
		field_t f;
		bit taken;
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cell_column <= col;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		predict_fields(col, f);
		pending_fields.push_back(f);
		n_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_fields.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// valid stays high between writes, the caller drops it after the last one
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] d);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		n_cfg++;
		case (idx)
			REG_PULSE_START: pulse_start_q = d;
			REG_RISE_LENGTH: rise_q = d[30:0];
			REG_FLAT_LENGTH: flat_q = d[30:0];
			REG_FALL_LENGTH: fall_q = d[30:0];
			REG_WAVE_NUMBER: wave_q = d[30:0];
			REG_AMP_COS:     amp_cos_q = d;
			REG_AMP_SIN:     amp_sin_q = d;
			REG_CELL_SIZE:   cell_q = d[30:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [31:0] st, input logic [31:0] ri,
			input logic [31:0] fl, input logic [31:0] fa, input logic [31:0] k,
			input logic [31:0] ac, input logic [31:0] as_, input logic [31:0] cs);
		write_reg(REG_PULSE_START, st);
		write_reg(REG_RISE_LENGTH, ri);
		write_reg(REG_FLAT_LENGTH, fl);
		write_reg(REG_FALL_LENGTH, fa);
		write_reg(REG_WAVE_NUMBER, k);
		write_reg(REG_AMP_COS, ac);
		write_reg(REG_AMP_SIN, as_);
		write_reg(REG_CELL_SIZE, cs);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		// defaults give zero amplitude, so every field is zero
		send_column(16'd0);
		send_column(16'd1);
		send_column(16'hffff);
		wait_idle();
	endtask

	task automatic test_directed();
		// pulse over the first cells, sine amplitude half the cosine amplitude, no carrier
		write_all(32'h0008_0000, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'd0,
			32'h0100_0000, 32'h0080_0000, 32'h0001_0000);
		for (int c = 0; c < 9; c++)
			send_column(c[15:0]);
		wait_idle();
		// empty rise and fall, upper bits of the data set, full-scale amplitudes
		write_all(32'h0004_0000, 32'h8000_0000, 32'h0002_0000, 32'h8000_0000, 32'h8003_0000,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_4000);
		for (int c = 0; c < 8; c++)
			send_column(c[15:0]);
		send_column(16'hffff);
		send_column(16'h5555);
		send_column(16'haaaa);
		wait_idle();
		// largest lengths and wave number, negative start
		write_all(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_column(16'd0);
		send_column(16'hffff);
		wait_idle();
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 10; ph++) begin
			logic [31:0] cs, ri, fl, fa;
			int centre;
			cs = (ph == 9) ? 32'd0 : $urandom_range(1, 32'h0002_0000);
			ri = (ph == 3) ? 32'd0 : cs * $urandom_range(1, 40) + $urandom_range(0, 255);
			fl = cs * $urandom_range(0, 30);
			fa = (ph == 5) ? 32'd0 : cs * $urandom_range(1, 40) + $urandom_range(0, 255);
			centre = $urandom_range(0, 400);
			write_all(cs * (centre + 60) + $urandom_range(0, 32'hffff), ri, fl, fa,
				(ph == 2) ? 32'd0 : {$urandom} >> $urandom_range(1, 14),
				$urandom, $urandom, cs);
			no_gaps = (ph == 4 || ph == 7);
			for (int i = 0; i < 120; i++) begin
				if ($urandom_range(0, 9) < 8)
					send_column(16'(centre + $urandom_range(0, 180)));
				else
					send_column(16'($urandom));
			end
			no_gaps = 1'b0;
			wait_idle();
		end
	endtask

	initial begin
		pulse_start_q = 32'd0;
		rise_q = 31'd65536;
		flat_q = 31'd0;
		fall_q = 31'd65536;
		wave_q = 31'd0;
		amp_cos_q = 32'd0;
		amp_sin_q = 32'd0;
		cell_q = 31'd65536;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed();
		test_random();
		wait_idle();
		$display("sent %0d cells, checked %0d field results, %0d register writes",
			n_sent, n_checked, n_cfg);
		$display("covered all envelope segments, empty ramps, saturation and random stalls");
		if (n_errors == 0 && pending_fields.size() == 0)
			$display("tb_plane_wave_pulse_field OK");
		else
			$display("tb_plane_wave_pulse_field NOT OK");
		$finish;
	end

endmodule
